// ===== rtl/core/rshc_pkg.sv =====
`timescale 1ns / 1ps

package rshc_pkg;

    localparam int STRIPE_W = 32;
    localparam int ID_W     = 16;

    // Request codes carried on the input tuser
    localparam logic [2:0] REQ_ACQUIRE     = 3'd0;
    localparam logic [2:0] REQ_RELEASE     = 3'd1;
    localparam logic [2:0] REQ_DISK_FAIL   = 3'd2;
    localparam logic [2:0] REQ_DISK_REPAIR = 3'd3;
    localparam logic [2:0] REQ_PROGRESS    = 3'd4;

    // Result codes carried on the output tuser
    localparam logic [3:0] OC_MAPPED     = 4'd0;
    localparam logic [3:0] OC_DEGRADED   = 4'd1;
    localparam logic [3:0] OC_RECOVERY   = 4'd2;
    localparam logic [3:0] OC_QUEUED     = 4'd3;
    localparam logic [3:0] OC_QUEUE_FULL = 4'd4;
    localparam logic [3:0] OC_RELEASED   = 4'd5;
    localparam logic [3:0] OC_REL_MISS   = 4'd6;
    localparam logic [3:0] OC_DISK       = 4'd7;
    localparam logic [3:0] OC_PROGRESS   = 4'd8;

    // Configuration register indexes
    localparam logic CFG_DISK_COUNT   = 1'b0;
    localparam logic CFG_HEADS_IN_USE = 1'b1;

endpackage

// ===== rtl/core/raid_stripe_head_cache_core.sv =====
`timescale 1ns / 1ps

// Stripe-head cache with a wait queue for a disk array controller.
// Requests enter on the s_axis channel (tuser = request code), one result per
// request leaves on the m_axis channel (tuser = result code); unknown request
// codes are consumed and give no result. cfg_we/cfg_index/cfg_data write the
// disk count and the number of heads in use; a heads write rebuilds the cache
// (all tags invalid, heads on the inactive list in index order, queue empty)
// in the same cycle. Write configuration only while the block is idle.
// Throughput: one request at a time; s_axis_tready is high only while idle.
// Acquire and release run a linear tag scan over NUM_HEADS entries of the
// tag memory, one per cycle, stopping at the first match; the shared
// remainder unit runs under that scan. A release that wakes a waiter scans
// again for the waiter. The result sits in an output register; if the
// receiver stalls, that result holds and a later finished result waits in
// the last step until the transfer completes. Reset puts the block into the
// same state as a rebuild with 64 heads and 4 disks, no disk failed,
// progress 0.
module raid_stripe_head_cache_core #(
    parameter int NUM_HEADS  = 64,
    parameter int MAX_DISKS  = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // stripe_number[31:0], request_id[47:32], recovery_request[48],
    // disk_number[52:49], zero fill
    input  logic [55:0] s_axis_tdata,
    // req_type
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // granted_id[15:0], head_index[21:16], pages_cleared[22],
    // failed_count[27:23], logical_failed_mask[43:28], zero fill
    output logic [47:0] m_axis_tdata,
    // outcome
    output logic [3:0]  m_axis_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int HEAD_W  = $clog2(NUM_HEADS);
    localparam int CNT_W   = $clog2(NUM_HEADS + 1);
    localparam int DIV_W   = $clog2(MAX_DISKS + 1);
    localparam int DIDX_W  = $clog2(MAX_DISKS);
    localparam int PTR_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FCNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int STRIPE_W = rshc_pkg::STRIPE_W;
    localparam int ID_W     = rshc_pkg::ID_W;
    localparam int FIFO_W   = STRIPE_W + ID_W + 1;
    // heads on the inactive list after reset: 64 saturated to the head count
    localparam int RESET_HEADS = (NUM_HEADS > 64) ? 64 : NUM_HEADS;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_SRCH_INIT = 11'b000_0000_0010,
        ST_SRCH      = 11'b000_0000_0100,
        ST_USR_RD    = 11'b000_0000_1000,
        ST_DECIDE    = 11'b000_0001_0000,
        ST_LR_RD     = 11'b000_0010_0000,
        ST_LR_UPD    = 11'b000_0100_0000,
        ST_POP_RD    = 11'b000_1000_0000,
        ST_POP_LD    = 11'b001_0000_0000,
        ST_MOD_WAIT  = 11'b010_0000_0000,
        ST_FINISH    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;

    // configuration and disk state
    logic [4:0]          cfg_disk_reg;
    logic [MAX_DISKS-1:0] fmask_reg;
    logic [DIV_W-1:0]    ftotal_reg;
    logic [STRIPE_W-1:0] progress_reg;

    // current request
    logic                is_rel_reg;
    logic [STRIPE_W-1:0] cur_stripe_reg;
    logic [ID_W-1:0]     cur_id_reg;
    logic                cur_kind_reg;

    // scan
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              cmp_vld_reg;
    logic [HEAD_W-1:0] cmp_idx_reg;
    logic              hit_reg;
    logic [HEAD_W-1:0] h_reg;
    logic              cleared_reg;

    // head bookkeeping flops
    logic [NUM_HEADS-1:0] valid_reg;
    logic [NUM_HEADS-1:0] nl_wr_reg;
    logic [NUM_HEADS-1:0] pl_wr_reg;
    logic [HEAD_W-1:0]    first_reg;
    logic [HEAD_W-1:0]    last_reg;
    logic [CNT_W-1:0]     lcnt_reg;

    // wait queue pointers
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [FCNT_W-1:0] fcnt_reg;

    // result
    logic [ID_W-1:0]   res_id_reg;
    logic [HEAD_W-1:0] res_head_reg;
    logic [3:0]        res_oc_reg;
    logic              res_clr_reg;
    logic              res_rot_reg;
    logic              m_valid_reg;
    logic [47:0]       m_data_reg;
    logic [3:0]        m_user_reg;

    // memories and their registered read data
    logic [STRIPE_W-1:0] tag_mem [NUM_HEADS];
    logic [ID_W-1:0]     users_mem [NUM_HEADS];
    logic [HEAD_W-1:0]   nl_mem [NUM_HEADS];
    logic [HEAD_W-1:0]   pl_mem [NUM_HEADS];
    logic [FIFO_W-1:0]   fifo_mem [WAIT_DEPTH];
    logic [STRIPE_W-1:0] tag_q;
    logic [ID_W-1:0]     users_q;
    logic [HEAD_W-1:0]   nxt_q;
    logic [HEAD_W-1:0]   prv_q;
    logic [FIFO_W-1:0]   fifo_q;

    // input fields
    logic [2:0]          in_type;
    logic [STRIPE_W-1:0] in_stripe;
    logic [ID_W-1:0]     in_id;
    logic                in_kind;
    logic [3:0]          in_disk;

    assign in_type   = s_axis_tuser;
    assign in_stripe = s_axis_tdata[31:0];
    assign in_id     = s_axis_tdata[47:32];
    assign in_kind   = s_axis_tdata[48];
    assign in_disk   = s_axis_tdata[52:49];

    logic s_fire;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // saturated disk count and head count
    logic [DIV_W-1:0] d_eff;
    logic [CNT_W-1:0] n_new;

    always_comb
    begin
        if (cfg_disk_reg == 5'd0)
            d_eff = DIV_W'(1);
        else if (32'(cfg_disk_reg) > MAX_DISKS)
            d_eff = DIV_W'(MAX_DISKS);
        else
            d_eff = DIV_W'(cfg_disk_reg);
    end

    always_comb
    begin
        if (cfg_data == 7'd0)
            n_new = CNT_W'(1);
        else if (32'(cfg_data) > NUM_HEADS)
            n_new = CNT_W'(NUM_HEADS);
        else
            n_new = CNT_W'(cfg_data);
    end

    // shared remainder unit: stripe mod disk count
    logic             mod_start;
    logic             mod_done;
    logic [DIV_W-1:0] mod_rem;

    assign mod_start = (state_reg == ST_SRCH_INIT);

    rshc_mod_unit #(
        .DIV_W(DIV_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cur_stripe_reg),
        .divisor  (d_eff),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    // scan compare
    logic              issue;
    logic              match;
    logic [HEAD_W-1:0] scan_idx;

    assign issue    = scan_cnt_reg < CNT_W'(NUM_HEADS);
    assign scan_idx = scan_cnt_reg[HEAD_W-1:0];
    assign match    = cmp_vld_reg && valid_reg[cmp_idx_reg] && (tag_q == cur_stripe_reg);

    // decision terms
    logic acq_hit_inc, acq_new, rel_ok, rel_zero, fifo_push, lr_mid;
    logic [3:0] grant_oc;

    assign acq_hit_inc = !is_rel_reg && hit_reg && (users_q != '1);
    assign acq_new     = !is_rel_reg && !hit_reg && (lcnt_reg != '0);
    assign rel_ok      = is_rel_reg && hit_reg && (users_q != '0);
    assign rel_zero    = rel_ok && (users_q == ID_W'(1));
    assign fifo_push   = (state_reg == ST_DECIDE) && !is_rel_reg && !hit_reg
                         && (lcnt_reg == '0) && (fcnt_reg < FCNT_W'(WAIT_DEPTH));
    assign lr_mid      = (lcnt_reg != CNT_W'(1)) && (h_reg != first_reg)
                         && (h_reg != last_reg);

    always_comb
    begin
        if (cur_kind_reg)
            grant_oc = rshc_pkg::OC_RECOVERY;
        else if ((ftotal_reg == '0) || (cur_stripe_reg < progress_reg))
            grant_oc = rshc_pkg::OC_MAPPED;
        else
            grant_oc = rshc_pkg::OC_DEGRADED;
    end

    // failed-disk mask rotated into stripe positions
    logic [MAX_DISKS-1:0] rot_mask;
    logic [DIV_W:0]       rot_idx [MAX_DISKS];

    always_comb
    begin
        for (int p = 0; p < MAX_DISKS; p++)
        begin
            rot_idx[p] = (DIV_W + 1)'(p) + {1'b0, mod_rem};
            if (rot_idx[p] >= {1'b0, d_eff})
                rot_idx[p] = rot_idx[p] - {1'b0, d_eff};
            rot_mask[p] = (p < 32'(d_eff)) ? fmask_reg[rot_idx[p][DIDX_W-1:0]] : 1'b0;
        end
    end

    // disk event terms
    logic                 disk_ok;
    logic [MAX_DISKS-1:0] disk_bit;

    assign disk_ok  = 32'(in_disk) < 32'(d_eff);
    assign disk_bit = {{(MAX_DISKS-1){1'b0}}, 1'b1} << in_disk;

    // output packing
    logic [63:0] mask64;
    logic [31:0] head32;
    logic [31:0] ftot32;
    logic        m_load;

    assign mask64 = res_rot_reg ? 64'(rot_mask) : 64'(fmask_reg);
    assign head32 = 32'(res_head_reg);
    assign ftot32 = 32'(ftotal_reg);
    assign m_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);

    // memories
    always_ff @(posedge clk)
    begin
        tag_q   <= tag_mem[scan_idx];
        users_q <= users_mem[h_reg];
        nxt_q   <= nl_wr_reg[h_reg] ? nl_mem[h_reg] : h_reg + 1'b1;
        prv_q   <= pl_wr_reg[h_reg] ? pl_mem[h_reg] : h_reg - 1'b1;
        fifo_q  <= fifo_mem[rd_ptr_reg];
        if (state_reg == ST_DECIDE)
        begin
            if (acq_new)
            begin
                tag_mem[first_reg]   <= cur_stripe_reg;
                users_mem[first_reg] <= ID_W'(1);
            end
            else if (acq_hit_inc)
                users_mem[h_reg] <= users_q + 1'b1;
            else if (rel_ok)
                users_mem[h_reg] <= users_q - 1'b1;
            // append the released head at the inactive tail
            if (rel_zero)
            begin
                if (lcnt_reg != '0)
                    nl_mem[last_reg] <= h_reg;
                pl_mem[h_reg] <= last_reg;
            end
        end
        if ((state_reg == ST_LR_UPD) && lr_mid)
        begin
            nl_mem[prv_q] <= nxt_q;
            pl_mem[nxt_q] <= prv_q;
        end
        if (fifo_push)
            fifo_mem[wr_ptr_reg] <= {cur_kind_reg, cur_id_reg, cur_stripe_reg};
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_disk_reg  <= 5'd4;
            fmask_reg     <= '0;
            ftotal_reg    <= '0;
            progress_reg  <= '0;
            valid_reg     <= '0;
            nl_wr_reg     <= '0;
            pl_wr_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= HEAD_W'(RESET_HEADS - 1);
            lcnt_reg      <= CNT_W'(RESET_HEADS);
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fcnt_reg      <= '0;
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (m_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    rshc_pkg::CFG_DISK_COUNT:
                        cfg_disk_reg <= cfg_data[4:0];
                    rshc_pkg::CFG_HEADS_IN_USE:
                    begin
                        valid_reg     <= '0;
                        nl_wr_reg     <= '0;
                        pl_wr_reg     <= '0;
                        first_reg     <= '0;
                        last_reg      <= HEAD_W'(n_new - 1'b1);
                        lcnt_reg      <= n_new;
                        rd_ptr_reg    <= '0;
                        wr_ptr_reg    <= '0;
                        fcnt_reg      <= '0;
                    end
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        cur_stripe_reg <= in_stripe;
                        cur_id_reg     <= in_id;
                        cur_kind_reg   <= in_kind;
                        res_id_reg     <= '0;
                        res_head_reg   <= '0;
                        res_clr_reg    <= 1'b0;
                        res_rot_reg    <= 1'b0;
                        priority case (in_type)
                            rshc_pkg::REQ_ACQUIRE, rshc_pkg::REQ_RELEASE:
                            begin
                                is_rel_reg <= (in_type == rshc_pkg::REQ_RELEASE);
                                state_reg  <= ST_SRCH_INIT;
                            end
                            rshc_pkg::REQ_DISK_FAIL:
                            begin
                                if (disk_ok)
                                begin
                                    if ((fmask_reg & disk_bit) == '0)
                                    begin
                                        fmask_reg  <= fmask_reg | disk_bit;
                                        ftotal_reg <= ftotal_reg + 1'b1;
                                    end
                                    progress_reg <= '0;
                                end
                                res_oc_reg <= rshc_pkg::OC_DISK;
                                state_reg  <= ST_FINISH;
                            end
                            rshc_pkg::REQ_DISK_REPAIR:
                            begin
                                if (disk_ok && ((fmask_reg & disk_bit) != '0))
                                begin
                                    fmask_reg  <= fmask_reg & ~disk_bit;
                                    ftotal_reg <= ftotal_reg - 1'b1;
                                end
                                res_oc_reg <= rshc_pkg::OC_DISK;
                                state_reg  <= ST_FINISH;
                            end
                            rshc_pkg::REQ_PROGRESS:
                            begin
                                progress_reg <= in_stripe;
                                res_oc_reg   <= rshc_pkg::OC_PROGRESS;
                                state_reg    <= ST_FINISH;
                            end
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SRCH_INIT:
                begin
                    scan_cnt_reg <= '0;
                    cmp_vld_reg  <= 1'b0;
                    cleared_reg  <= 1'b0;
                    state_reg    <= ST_SRCH;
                end
                ST_SRCH:
                begin
                    if (issue)
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    cmp_vld_reg <= issue;
                    cmp_idx_reg <= scan_idx;
                    if (match)
                    begin
                        hit_reg   <= 1'b1;
                        h_reg     <= cmp_idx_reg;
                        state_reg <= ST_USR_RD;
                    end
                    else if (!issue)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_USR_RD:
                    state_reg <= ST_DECIDE;
                ST_DECIDE:
                begin
                    res_rot_reg <= 1'b1;
                    if (!is_rel_reg)
                    begin
                        if (hit_reg)
                        begin
                            if (acq_hit_inc && (users_q == '0))
                                state_reg <= ST_LR_RD;
                            else
                            begin
                                res_oc_reg   <= grant_oc;
                                res_id_reg   <= cur_id_reg;
                                res_head_reg <= h_reg;
                                res_clr_reg  <= 1'b0;
                                state_reg    <= ST_MOD_WAIT;
                            end
                        end
                        else if (acq_new)
                        begin
                            // take the oldest inactive head and retag it
                            h_reg                <= first_reg;
                            cleared_reg          <= valid_reg[first_reg];
                            valid_reg[first_reg] <= 1'b1;
                            state_reg            <= ST_LR_RD;
                        end
                        else
                        begin
                            if (fifo_push)
                            begin
                                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                              '0 : wr_ptr_reg + 1'b1;
                                fcnt_reg   <= fcnt_reg + 1'b1;
                                res_oc_reg <= rshc_pkg::OC_QUEUED;
                            end
                            else
                                res_oc_reg <= rshc_pkg::OC_QUEUE_FULL;
                            res_id_reg   <= cur_id_reg;
                            res_head_reg <= '0;
                            res_clr_reg  <= 1'b0;
                            state_reg    <= ST_MOD_WAIT;
                        end
                    end
                    else if (!rel_ok)
                    begin
                        res_oc_reg <= rshc_pkg::OC_REL_MISS;
                        state_reg  <= ST_MOD_WAIT;
                    end
                    else if (!rel_zero)
                    begin
                        res_oc_reg   <= rshc_pkg::OC_RELEASED;
                        res_head_reg <= h_reg;
                        state_reg    <= ST_MOD_WAIT;
                    end
                    else
                    begin
                        if (lcnt_reg == '0)
                            first_reg <= h_reg;
                        else
                            nl_wr_reg[last_reg] <= 1'b1;
                        pl_wr_reg[h_reg] <= 1'b1;
                        last_reg         <= h_reg;
                        lcnt_reg         <= lcnt_reg + 1'b1;
                        if (fcnt_reg != '0)
                            state_reg <= ST_POP_RD;
                        else
                        begin
                            res_oc_reg   <= rshc_pkg::OC_RELEASED;
                            res_head_reg <= h_reg;
                            res_clr_reg  <= 1'b1;
                            state_reg    <= ST_MOD_WAIT;
                        end
                    end
                end
                ST_LR_RD:
                    state_reg <= ST_LR_UPD;
                ST_LR_UPD:
                begin
                    // unlink the head from the inactive list
                    if (lcnt_reg != CNT_W'(1))
                    begin
                        if (h_reg == first_reg)
                            first_reg <= nxt_q;
                        else if (h_reg == last_reg)
                            last_reg <= prv_q;
                        else
                        begin
                            nl_wr_reg[prv_q] <= 1'b1;
                            pl_wr_reg[nxt_q] <= 1'b1;
                        end
                    end
                    lcnt_reg     <= lcnt_reg - 1'b1;
                    res_oc_reg   <= grant_oc;
                    res_id_reg   <= cur_id_reg;
                    res_head_reg <= h_reg;
                    res_clr_reg  <= cleared_reg;
                    state_reg    <= ST_MOD_WAIT;
                end
                ST_POP_RD:
                begin
                    rd_ptr_reg <= (rd_ptr_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                  '0 : rd_ptr_reg + 1'b1;
                    fcnt_reg   <= fcnt_reg - 1'b1;
                    state_reg  <= ST_POP_LD;
                end
                ST_POP_LD:
                begin
                    // run the woken waiter as a fresh acquire
                    cur_stripe_reg <= fifo_q[STRIPE_W-1:0];
                    cur_id_reg     <= fifo_q[STRIPE_W+ID_W-1:STRIPE_W];
                    cur_kind_reg   <= fifo_q[FIFO_W-1];
                    is_rel_reg     <= 1'b0;
                    state_reg      <= ST_SRCH_INIT;
                end
                ST_MOD_WAIT:
                begin
                    if (mod_done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (m_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            m_data_reg <= {4'b0, mask64[15:0], ftot32[4:0], res_clr_reg,
                           head32[5:0], res_id_reg};
            m_user_reg <= res_oc_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_list_bound : assert property (@(posedge clk) disable iff (!rst_n)
        lcnt_reg <= CNT_W'(NUM_HEADS))
        else $error("inactive list count above head count");

    a_fifo_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCNT_W'(WAIT_DEPTH))
        else $error("wait queue count above depth");

    a_ftotal : assert property (@(posedge clk) disable iff (!rst_n)
        32'(ftotal_reg) == $countones(fmask_reg))
        else $error("failed total out of step with failed mask");

    a_rot_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && res_rot_reg |-> mod_done)
        else $error("result rotation used before remainder is done");
`endif

endmodule

// ===== rtl/core/rshc_mod_unit.sv =====
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle.
module rshc_mod_unit #(
    parameter int DIV_W = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rshc_pkg::STRIPE_W-1:0] dividend,
    input  logic [DIV_W-1:0]             divisor,
    output logic                         done,
    output logic [DIV_W-1:0]             remainder
);

    localparam int CNT_W = $clog2(rshc_pkg::STRIPE_W);

    logic [rshc_pkg::STRIPE_W-1:0] quo_reg;
    logic [DIV_W-1:0]              rem_reg;
    logic [DIV_W-1:0]              div_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [DIV_W:0]                trial;
    logic [DIV_W:0]                diff;

    assign trial = {rem_reg, quo_reg[rshc_pkg::STRIPE_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(rshc_pkg::STRIPE_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[rshc_pkg::STRIPE_W-2:0], 1'b0};
            // keep the partial remainder below the divisor
            if (trial >= {1'b0, div_reg})
                rem_reg <= diff[DIV_W-1:0];
            else
                rem_reg <= trial[DIV_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== tb/sv/rshc_result_checker.sv =====
`timescale 1ns / 1ps

module rshc_result_checker #(
    parameter int NUM_HEADS  = 64,
    parameter int MAX_DISKS  = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [3:0]  m_axis_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [15:0] granted_id;
        logic [5:0]  head_index;
        logic [3:0]  outcome;
        logic        pages_cleared;
        logic [4:0]  failed_count;
        logic [15:0] mask;
    } grant_t;

    grant_t pending_grants[$];

    logic [31:0] tag[NUM_HEADS];
    logic        tag_valid[NUM_HEADS];
    logic [15:0] users[NUM_HEADS];
    int          nxt[NUM_HEADS];
    int          prv[NUM_HEADS];
    int          lru_first, lru_last, lru_count;
    logic [31:0] wq_stripe[WAIT_DEPTH];
    logic [15:0] wq_id[WAIT_DEPTH];
    logic        wq_kind[WAIT_DEPTH];
    int          wq_rd, wq_cnt;
    logic [15:0] dead_mask;
    logic [4:0]  dead_total;
    logic [31:0] progress;
    logic [4:0]  disks_reg;
    logic [6:0]  heads_reg;

    function automatic int disk_span();
        if (disks_reg == 0) return 1;
        if (disks_reg > MAX_DISKS) return MAX_DISKS;
        return disks_reg;
    endfunction

    function automatic logic [15:0] rotate_dead(logic [31:0] stripe);
        int d;
        int r;
        logic [15:0] m;
        d = disk_span();
        r = stripe % d;
        m = '0;
        for (int i = 0; i < d; i++)
            if (dead_mask[i]) m[(i + d - r) % d] = 1'b1;
        return m;
    endfunction

    function automatic void unlink(int h);
        if (lru_count == 0) return;
        if (lru_count == 1) begin
            lru_count = 0;
            return;
        end
        if (h == lru_first) lru_first = nxt[h];
        else if (h == lru_last) lru_last = prv[h];
        else begin
            nxt[prv[h]] = nxt[h];
            prv[nxt[h]] = prv[h];
        end
        lru_count--;
    endfunction

    function automatic void link_tail(int h);
        if (lru_count == 0) lru_first = h;
        else nxt[lru_last] = h;
        prv[h] = lru_last;
        lru_last = h;
        lru_count++;
    endfunction

    function automatic void rebuild();
        int n;
        n = (heads_reg == 0) ? 1 : ((heads_reg > NUM_HEADS) ? NUM_HEADS : heads_reg);
        for (int i = 0; i < NUM_HEADS; i++) begin
            tag[i] = '0;
            tag_valid[i] = 1'b0;
            users[i] = '0;
            nxt[i] = 0;
            prv[i] = 0;
        end
        lru_first = 0;
        lru_last = 0;
        lru_count = 0;
        for (int i = 0; i < n; i++) link_tail(i);
        wq_rd = 0;
        wq_cnt = 0;
    endfunction

    function automatic void push_grant(logic [15:0] id, int head, logic [3:0] oc,
                                       logic cleared, logic [15:0] mask);
        grant_t g;
        g.granted_id = id;
        g.head_index = head[5:0];
        g.outcome = oc;
        g.pages_cleared = cleared;
        g.failed_count = dead_total;
        g.mask = mask;
        pending_grants.push_back(g);
    endfunction

    function automatic int lookup(logic [31:0] stripe);
        for (int i = 0; i < NUM_HEADS; i++)
            if (tag_valid[i] && tag[i] == stripe) return i;
        return -1;
    endfunction

    function automatic void predict_acquire(logic [31:0] stripe, logic [15:0] id, logic kind);
        int h;
        logic cleared;
        logic [3:0] oc;
        h = lookup(stripe);
        cleared = 1'b0;
        if (h >= 0) begin
            if (users[h] != 16'hFFFF) begin
                users[h]++;
                if (users[h] == 1) unlink(h);
            end
        end else if (lru_count > 0) begin
            h = lru_first;
            unlink(h);
            cleared = tag_valid[h];
            tag[h] = stripe;
            tag_valid[h] = 1'b1;
            users[h] = 1;
        end else begin
            if (wq_cnt < WAIT_DEPTH) begin
                int w;
                w = (wq_rd + wq_cnt) % WAIT_DEPTH;
                wq_stripe[w] = stripe;
                wq_id[w] = id;
                wq_kind[w] = kind;
                wq_cnt++;
                oc = rshc_pkg::OC_QUEUED;
            end else begin
                oc = rshc_pkg::OC_QUEUE_FULL;
            end
            push_grant(id, 0, oc, 1'b0, rotate_dead(stripe));
            return;
        end
        if (kind) oc = rshc_pkg::OC_RECOVERY;
        else if (dead_total == 0 || stripe < progress) oc = rshc_pkg::OC_MAPPED;
        else oc = rshc_pkg::OC_DEGRADED;
        push_grant(id, h, oc, cleared, rotate_dead(stripe));
    endfunction

    function automatic void predict_release(logic [31:0] stripe);
        int h;
        int w;
        h = lookup(stripe);
        if (h < 0 || users[h] == 0) begin
            push_grant('0, 0, rshc_pkg::OC_REL_MISS, 1'b0, rotate_dead(stripe));
            return;
        end
        users[h]--;
        if (users[h] != 0) begin
            push_grant('0, h, rshc_pkg::OC_RELEASED, 1'b0, rotate_dead(stripe));
            return;
        end
        link_tail(h);
        if (wq_cnt > 0) begin
            w = wq_rd;
            wq_rd = (wq_rd + 1) % WAIT_DEPTH;
            wq_cnt--;
            predict_acquire(wq_stripe[w], wq_id[w], wq_kind[w]);
            return;
        end
        push_grant('0, h, rshc_pkg::OC_RELEASED, 1'b1, rotate_dead(stripe));
    endfunction

    function automatic void predict_disk(logic [2:0] kind, logic [3:0] disk);
        if (disk < disk_span()) begin
            if (kind == rshc_pkg::REQ_DISK_FAIL) begin
                if (!dead_mask[disk]) begin
                    dead_mask[disk] = 1'b1;
                    dead_total++;
                end
                progress = '0;
            end else if (dead_mask[disk]) begin
                dead_mask[disk] = 1'b0;
                dead_total--;
            end
        end
        push_grant('0, 0, rshc_pkg::OC_DISK, 1'b0, dead_mask);
    endfunction

    function automatic void compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count = 0;
        disks_reg = 5'd4;
        heads_reg = 7'd64;
        dead_mask = '0;
        dead_total = '0;
        progress = '0;
        rebuild();
    end

    assign pending_count = pending_grants.size();

    always @(posedge clk)
    begin
        grant_t g;
        logic [31:0] stripe;
        if (rst_n) begin
            // the bench must make configuration writes only while the block is idle; this checker does not enforce it
            if (cfg_we) begin
                if (cfg_index == rshc_pkg::CFG_DISK_COUNT) disks_reg = cfg_data[4:0];
                else begin
                    heads_reg = cfg_data;
                    rebuild();
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                stripe = s_axis_tdata[31:0];
                case (s_axis_tuser)
                    rshc_pkg::REQ_ACQUIRE:
                        predict_acquire(stripe, s_axis_tdata[47:32], s_axis_tdata[48]);
                    rshc_pkg::REQ_RELEASE:
                        predict_release(stripe);
                    rshc_pkg::REQ_DISK_FAIL, rshc_pkg::REQ_DISK_REPAIR:
                        predict_disk(s_axis_tuser, s_axis_tdata[52:49]);
                    rshc_pkg::REQ_PROGRESS:
                    begin
                        progress = stripe;
                        push_grant('0, 0, rshc_pkg::OC_PROGRESS, 1'b0, dead_mask);
                    end
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_grants.size() == 0) begin
                    $error("unexpected result transfer: tdata %0h tuser %0h",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    g = pending_grants.pop_front();
                    compare("granted_id", g.granted_id, m_axis_tdata[15:0]);
                    compare("head_index", g.head_index, m_axis_tdata[21:16]);
                    compare("outcome", g.outcome, m_axis_tuser);
                    compare("pages_cleared", g.pages_cleared, m_axis_tdata[22]);
                    compare("failed_count", g.failed_count, m_axis_tdata[27:23]);
                    compare("logical_failed_mask", g.mask, m_axis_tdata[43:28]);
                end
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Slowest item: a release that wakes a waiter rescans all heads
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 2000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    int          fail_count;
    int          pending_count;
    int          cycle_count;
    int          stall_left;
    bit          calm;          // set for the last stretch: no random idling on either side
    logic [31:0] stripe_pool[6];

    raid_stripe_head_cache_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rshc_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: end the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("raid_stripe_head_cache_core test failed");
            $finish;
        end
    end

    // Receiver: stall in random bursts, never once calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Present one request and hold it until the transfer completes
    task automatic send(logic [2:0] kind, logic [31:0] stripe, logic [15:0] id,
                        logic rec, logic [3:0] disk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, disk, rec, id, stripe};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Hold off until every expected result has come, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly acquire/release traffic on a small pool of stripes so heads
    // fill, waiters queue and releases wake them; the rest is disk events,
    // progress updates, stray stripes and unknown codes.
    task automatic random_request();
        int pick;
        logic [31:0] stripe;
        pick = $urandom_range(0, 99);
        stripe = stripe_pool[$urandom_range(0, 5)];
        if (pick < 45)
            send(rshc_pkg::REQ_ACQUIRE, stripe, 16'($urandom), 1'($urandom),
                 4'($urandom));
        else if (pick < 80)
            send(rshc_pkg::REQ_RELEASE, stripe, 16'($urandom), 1'($urandom),
                 4'($urandom));
        else if (pick < 85)
            send(rshc_pkg::REQ_ACQUIRE, $urandom, 16'($urandom), 1'($urandom),
                 4'($urandom));
        else if (pick < 88)
            send(rshc_pkg::REQ_RELEASE, $urandom, 16'($urandom), 1'($urandom),
                 4'($urandom));
        else if (pick < 93)
            send(rshc_pkg::REQ_DISK_FAIL, $urandom, 16'($urandom), 1'($urandom),
                 4'($urandom));
        else if (pick < 96)
            send(rshc_pkg::REQ_DISK_REPAIR, $urandom, 16'($urandom), 1'($urandom),
                 4'($urandom));
        else if (pick < 98)
            send(rshc_pkg::REQ_PROGRESS, $urandom, 16'($urandom), 1'($urandom),
                 4'($urandom));
        else
            send(3'($urandom_range(5, 7)), $urandom, 16'($urandom), 1'($urandom),
                 4'($urandom));
    endtask

    initial
    begin
        logic [4:0] disk_set[8];
        logic [6:0] head_set[8];
        logic [31:0] base;
        disk_set = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd7, 5'd5, 5'd3, 5'd4};
        head_set = '{7'd1, 7'd2, 7'd4, 7'd64, 7'd3, 7'd127, 7'd0, 7'd1};
        calm = 1'b0;
        cycle_count = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: hit, miss, recovery, release paths, disk events, progress, unknown codes
        send(rshc_pkg::REQ_ACQUIRE, 32'h0, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 4'hF);
        send(rshc_pkg::REQ_ACQUIRE, 32'h0, 16'h1234, 1'b0, 4'h0);
        send(rshc_pkg::REQ_RELEASE, 32'h0, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_RELEASE, 32'h0, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_RELEASE, 32'h0, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_RELEASE, 32'h0001_2345, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_DISK_FAIL, 32'h0, 16'h0, 1'b0, 4'd3);
        send(rshc_pkg::REQ_DISK_FAIL, 32'h0, 16'h0, 1'b0, 4'd15);
        send(rshc_pkg::REQ_ACQUIRE, 32'd5, 16'h0042, 1'b0, 4'h0);
        send(rshc_pkg::REQ_PROGRESS, 32'd100, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_ACQUIRE, 32'd7, 16'h0043, 1'b0, 4'h0);
        send(rshc_pkg::REQ_DISK_REPAIR, 32'h0, 16'h0, 1'b0, 4'd3);
        send(rshc_pkg::REQ_DISK_REPAIR, 32'h0, 16'h0, 1'b0, 4'd9);
        send(3'd5, 32'h0, 16'h0, 1'b0, 4'h0);
        send(3'd7, 32'h0, 16'h0, 1'b0, 4'h0);

        // One head: second and third acquire queue, releases wake them in order
        write_reg(rshc_pkg::CFG_HEADS_IN_USE, 7'd1);
        send(rshc_pkg::REQ_DISK_FAIL, 32'h0, 16'h0, 1'b0, 4'd1);
        send(rshc_pkg::REQ_ACQUIRE, 32'd10, 16'h0A, 1'b0, 4'h0);
        send(rshc_pkg::REQ_ACQUIRE, 32'd11, 16'h0B, 1'b0, 4'h0);
        send(rshc_pkg::REQ_ACQUIRE, 32'd12, 16'h0C, 1'b1, 4'h0);
        send(rshc_pkg::REQ_RELEASE, 32'd10, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_RELEASE, 32'd11, 16'h0, 1'b0, 4'h0);
        send(rshc_pkg::REQ_RELEASE, 32'd12, 16'h0, 1'b0, 4'h0);

        // Random phases over a spread of register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(rshc_pkg::CFG_DISK_COUNT, disk_set[ph]);
            write_reg(rshc_pkg::CFG_HEADS_IN_USE, head_set[ph]);
            base = $urandom;
            for (int i = 0; i < 6; i++)
                stripe_pool[i] = ($urandom_range(0, 1) == 0) ? base + i : 32'(i * 3);
            if (ph == 7) calm = 1'b1;
            for (int n = 0; n < 125; n++) begin
                random_request();
                if (n == 60) drain();
                else sender_gap();
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("raid_stripe_head_cache_core test passed");
        else
            $display("raid_stripe_head_cache_core test failed");
        $finish;
    end

endmodule
